[hw/rtl/link_rx_quality_estimator_defines.svh]
// ----------------------------------------------------------------------------
// link_rx_quality_estimator_defines
// assertion helpers for the link receive quality estimator
// ----------------------------------------------------------------------------
`ifndef LINK_RX_QUALITY_ESTIMATOR_DEFINES_SVH
`define LINK_RX_QUALITY_ESTIMATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LRQE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LRQE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lrqe_pkg.sv]
// ----------------------------------------------------------------------------
// lrqe_pkg
// shared types and constants of the link receive quality estimator
// ----------------------------------------------------------------------------
package lrqe_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 20;
    localparam int SUM_W   = COUNT_W + 1;
    localparam int PROD_W  = TIME_W + SUM_W;
    localparam int QUO_W   = COUNT_W;
    localparam int STEP_W  = 5;
    localparam int Q_W     = 7;
    localparam int SLOW_W  = 13;
    localparam int SLOWUS_W = 33;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TIME_W-1:0] FAST_US = 32'd500000;
    localparam logic [TIME_W-1:0] IDLE_MIN_US = 32'd200000;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [Q_W-1:0] Q_MAX = 7'd100;

    localparam logic [COUNT_W-1:0] FAST_MIN_RST = 20'd25;
    localparam logic [SLOW_W-1:0] SLOW_S_RST = 13'd5;
    localparam logic [SLOWUS_W-1:0] SLOW_US_RST = 33'd5000000;

    localparam logic REG_FAST_MIN = 1'b0;
    localparam logic REG_SLOW_S   = 1'b1;

    localparam logic [STEP_W-1:0] A_TOP_STEP = 5'd19;
    localparam logic [STEP_W-1:0] B_TOP_STEP = 5'd6;
    localparam int A_CELLS = 20;
    localparam int B_CELLS = 7;

    typedef struct packed {
        logic [TIME_W-1:0]  now_us;
        logic [TIME_W-1:0]  timer_start_us;
        logic [TIME_W-1:0]  first_frame_us;
        logic [TIME_W-1:0]  last_frame_us;
        logic [COUNT_W-1:0] captured_count;
        logic [COUNT_W-1:0] missed_count;
    } in_t;

    typedef struct packed {
        logic               update_fired;
        logic [Q_W-1:0]     quality_percent;
        logic [COUNT_W-1:0] total_missed;
    } out_t;

    // side data that rides along with an item through the cells
    typedef struct packed {
        logic               fired;
        logic               qen;
        logic               ex;
        logic               sat;
        logic [COUNT_W-1:0] capt;
        logic [COUNT_W-1:0] miss;
    } ctx_t;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [TIME_W-1:0] den;
        logic [QUO_W-1:0]  quo;
    } div_t;

endpackage

[hw/rtl/link_rx_quality_estimator.sv]
// ----------------------------------------------------------------------------
// link_rx_quality_estimator
// per-entry receive quality update with idle-time missed-frame extrapolation
// ----------------------------------------------------------------------------
// path: stages 0 to 2, extrapolation cells, total stage, quality cells, output register
// throughput: one item per cycle while the output is not stalled; the 20 + 7 division cells each take a new
//   item every cycle, one quotient bit per cell
// reset: rst_n clears all valid bits and loads registers with 25 and 5
// a stall on the output freezes the whole pipeline in place
module link_rx_quality_estimator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lrqe_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lrqe_pkg::out_t              out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrqe_pkg::ADDR_W-1:0] paddr,
    input  logic [lrqe_pkg::DATA_W-1:0] pwdata,
    output logic [lrqe_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    // global advance: everything moves unless the result waits
    logic en;

    // configuration registers; slow interval also kept in microseconds
    logic [lrqe_pkg::COUNT_W-1:0]  fast_min_reg;
    logic [lrqe_pkg::SLOW_W-1:0]   slow_s_reg;
    logic [lrqe_pkg::SLOWUS_W-1:0] slow_us_reg;
    logic                          wr;

    // stage 0: time differences and decisions
    logic                         s0_valid_reg;
    lrqe_pkg::ctx_t               s0_ctx_reg, s0_ctx_next;
    logic [lrqe_pkg::TIME_W-1:0]  s0_idle_reg, s0_idle_next;
    logic [lrqe_pkg::TIME_W-1:0]  s0_span_reg, s0_span_next;
    logic [lrqe_pkg::SUM_W-1:0]   s0_sum_reg;
    logic [lrqe_pkg::TIME_W-1:0]  elapsed;

    // stage 1: idle * (captured + missed)
    logic                         s1_valid_reg;
    lrqe_pkg::ctx_t               s1_ctx_reg;
    logic [lrqe_pkg::PROD_W-1:0]  s1_prod_reg;
    logic [lrqe_pkg::TIME_W-1:0]  s1_span_reg;

    // stage 2: saturation check ahead of the extrapolation divider
    logic                         s2_valid_reg;
    lrqe_pkg::ctx_t               s2_ctx_reg, s2_ctx_next;
    lrqe_pkg::div_t               s2_div_reg, s2_div_next;

    // extrapolation divider chain
    logic           a_v [0:lrqe_pkg::A_CELLS];
    lrqe_pkg::ctx_t a_c [0:lrqe_pkg::A_CELLS];
    lrqe_pkg::div_t a_d [0:lrqe_pkg::A_CELLS];

    // total stage
    logic                         t_valid_reg;
    lrqe_pkg::ctx_t               t_ctx_reg;
    logic [lrqe_pkg::COUNT_W-1:0] t_total_reg, t_total_next;
    logic [lrqe_pkg::SUM_W-1:0]   t_add;

    // quality divider chain
    logic           b_v [0:lrqe_pkg::B_CELLS];
    lrqe_pkg::ctx_t b_c [0:lrqe_pkg::B_CELLS];
    lrqe_pkg::div_t b_d [0:lrqe_pkg::B_CELLS];
    logic [lrqe_pkg::SUM_W-1:0] b_den;

    // output register
    logic            out_valid_reg;
    lrqe_pkg::out_t  out_reg, out_next;
    logic [lrqe_pkg::Q_W-1:0] q_raw;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_min_reg <= lrqe_pkg::FAST_MIN_RST;
            slow_s_reg   <= lrqe_pkg::SLOW_S_RST;
            slow_us_reg  <= lrqe_pkg::SLOW_US_RST;
        end
        else if (wr)
        begin
            case (paddr[2])
                lrqe_pkg::REG_FAST_MIN:
                begin
                    fast_min_reg <= pwdata[lrqe_pkg::COUNT_W-1:0];
                end
                lrqe_pkg::REG_SLOW_S:
                begin
                    slow_s_reg  <= pwdata[lrqe_pkg::SLOW_W-1:0];
                    slow_us_reg <= lrqe_pkg::SLOWUS_W'(pwdata[lrqe_pkg::SLOW_W-1:0])
                                   * lrqe_pkg::SLOWUS_W'(lrqe_pkg::US_PER_S);
                end
                default:
                begin
                    fast_min_reg <= fast_min_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lrqe_pkg::REG_FAST_MIN: prdata = {{(lrqe_pkg::DATA_W-lrqe_pkg::COUNT_W){1'b0}},
                                             fast_min_reg};
            lrqe_pkg::REG_SLOW_S:   prdata = {{(lrqe_pkg::DATA_W-lrqe_pkg::SLOW_W){1'b0}},
                                             slow_s_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- stage 0 ----------------
    // all differences wrap at the time width
    always_comb
    begin
        elapsed = in_data.now_us - in_data.timer_start_us;
        s0_span_next = in_data.last_frame_us - in_data.first_frame_us;
        s0_idle_next = (in_data.first_frame_us - in_data.timer_start_us)
                     + (in_data.now_us - in_data.last_frame_us);
        s0_ctx_next.fired = ((in_data.captured_count >= fast_min_reg)
                             && (elapsed > lrqe_pkg::FAST_US))
                            || ({1'b0, elapsed} > slow_us_reg);
        s0_ctx_next.qen  = s0_ctx_next.fired && (in_data.captured_count > 20'd1);
        s0_ctx_next.ex   = s0_ctx_next.qen && (s0_span_next != '0)
                           && (s0_idle_next > lrqe_pkg::IDLE_MIN_US);
        s0_ctx_next.sat  = 1'b0;
        s0_ctx_next.capt = in_data.captured_count;
        s0_ctx_next.miss = in_data.missed_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            t_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            t_valid_reg   <= a_v[lrqe_pkg::A_CELLS];
            out_valid_reg <= b_v[lrqe_pkg::B_CELLS];
        end
    end

    // ---------------- stages 1 and 2 ----------------
    always_comb
    begin
        s2_ctx_next = s1_ctx_reg;
        // quotient would not fit the count width: saturate
        s2_ctx_next.sat = (s1_prod_reg >= {1'b0, s1_span_reg, {lrqe_pkg::COUNT_W{1'b0}}});
        s2_div_next.rem = s1_prod_reg;
        s2_div_next.den = s1_span_reg;
        s2_div_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctx_reg  <= s0_ctx_next;
            s0_idle_reg <= s0_idle_next;
            s0_span_reg <= s0_span_next;
            s0_sum_reg  <= {1'b0, in_data.captured_count} + {1'b0, in_data.missed_count};
            s1_ctx_reg  <= s0_ctx_reg;
            s1_prod_reg <= s0_idle_reg * s0_sum_reg;
            s1_span_reg <= s0_span_reg;
            s2_ctx_reg  <= s2_ctx_next;
            s2_div_reg  <= s2_div_next;
            t_ctx_reg   <= a_c[lrqe_pkg::A_CELLS];
            t_total_reg <= t_total_next;
            out_reg     <= out_next;
        end
    end

    // ---------------- extrapolation chain, quotient bits 19 down to 0 ----------------
    assign a_v[0] = s2_valid_reg;
    assign a_c[0] = s2_ctx_reg;
    assign a_d[0] = s2_div_reg;

    for (genvar i = 0; i < lrqe_pkg::A_CELLS; i++)
    begin : g_a
        lrqe_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .step    (lrqe_pkg::A_TOP_STEP - lrqe_pkg::STEP_W'(i)),
            .valid   (a_v[i]),
            .ctx     (a_c[i]),
            .div     (a_d[i]),
            .valid_q (a_v[i+1]),
            .ctx_q   (a_c[i+1]),
            .div_q   (a_d[i+1])
        );
    end

    // ---------------- total missed, saturating ----------------
    always_comb
    begin
        t_add = {1'b0, a_c[lrqe_pkg::A_CELLS].miss} + {1'b0, a_d[lrqe_pkg::A_CELLS].quo};
        if (!a_c[lrqe_pkg::A_CELLS].ex)
        begin
            t_total_next = a_c[lrqe_pkg::A_CELLS].miss;
        end
        else if (a_c[lrqe_pkg::A_CELLS].sat || (t_add >= {1'b0, lrqe_pkg::COUNT_MAX}))
        begin
            t_total_next = lrqe_pkg::COUNT_MAX;
        end
        else
        begin
            t_total_next = t_add[lrqe_pkg::COUNT_W-1:0];
        end
    end

    // ---------------- quality chain, 100 * captured / (captured + total) ----------------
    always_comb
    begin
        b_den = {1'b0, t_ctx_reg.capt} + {1'b0, t_total_reg};
        b_c[0] = t_ctx_reg;
        b_c[0].miss = t_total_reg;
        b_d[0].rem = lrqe_pkg::PROD_W'(t_ctx_reg.capt) * lrqe_pkg::PROD_W'(lrqe_pkg::Q_MAX);
        b_d[0].den = {{(lrqe_pkg::TIME_W-lrqe_pkg::SUM_W){1'b0}}, b_den};
        b_d[0].quo = '0;
    end
    assign b_v[0] = t_valid_reg;

    for (genvar j = 0; j < lrqe_pkg::B_CELLS; j++)
    begin : g_b
        lrqe_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .step    (lrqe_pkg::B_TOP_STEP - lrqe_pkg::STEP_W'(j)),
            .valid   (b_v[j]),
            .ctx     (b_c[j]),
            .div     (b_d[j]),
            .valid_q (b_v[j+1]),
            .ctx_q   (b_c[j+1]),
            .div_q   (b_d[j+1])
        );
    end

    // ---------------- output ----------------
    always_comb
    begin
        q_raw = b_d[lrqe_pkg::B_CELLS].quo[lrqe_pkg::Q_W-1:0];
        out_next.update_fired = b_c[lrqe_pkg::B_CELLS].fired;
        out_next.total_missed = b_c[lrqe_pkg::B_CELLS].miss;
        if (!b_c[lrqe_pkg::B_CELLS].qen)
        begin
            out_next.quality_percent = '0;
        end
        else if (q_raw > lrqe_pkg::Q_MAX)
        begin
            out_next.quality_percent = lrqe_pkg::Q_MAX;
        end
        else
        begin
            out_next.quality_percent = q_raw;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`include "link_rx_quality_estimator_defines.svh"

    `LRQE_ASSERT_NOW(a_q_range, out_valid_reg, out_reg.quality_percent <= lrqe_pkg::Q_MAX, "quality above 100")
    `LRQE_ASSERT_NOW(a_q_fired, out_valid_reg && !out_reg.update_fired, out_reg.quality_percent == '0, "quality without update")
    `LRQE_ASSERT_NOW(a_no_ex, t_valid_reg && !t_ctx_reg.ex, t_total_reg == t_ctx_reg.miss, "total changed without extrapolation")

endmodule

[hw/rtl/lrqe_cell.sv]
// ----------------------------------------------------------------------------
// lrqe_cell
// one restoring division step: settles one quotient bit and passes on
// ----------------------------------------------------------------------------
module lrqe_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [lrqe_pkg::STEP_W-1:0] step,
    input  logic                        valid,
    input  lrqe_pkg::ctx_t              ctx,
    input  lrqe_pkg::div_t              div,
    output logic                        valid_q,
    output lrqe_pkg::ctx_t              ctx_q,
    output lrqe_pkg::div_t              div_q
);

    logic [lrqe_pkg::PROD_W-1:0] shifted;
    logic                        ge;
    lrqe_pkg::div_t              div_next;
    logic                        valid_reg;
    lrqe_pkg::ctx_t              ctx_reg;
    lrqe_pkg::div_t              div_reg;

    always_comb
    begin
        shifted = {{(lrqe_pkg::PROD_W-lrqe_pkg::TIME_W){1'b0}}, div.den} << step;
        ge = (div.rem >= shifted);
        div_next = div;
        if (ge)
        begin
            div_next.rem = div.rem - shifted;
        end
        div_next.quo[step] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx;
            div_reg <= div_next;
        end
    end

    assign valid_q = valid_reg;
    assign ctx_q   = ctx_reg;
    assign div_q   = div_reg;

endmodule
